>>> rtl/core/dxt1bd_pkg.sv
// Shared types and constants of the DXT1 block decoder.
package dxt1bd_pkg;

    // Texels in one 4x4 block and the width of the texel counter.
    localparam int TEXELS    = 16;
    localparam int CNT_W     = $clog2(TEXELS);

    // Channel widths.
    localparam int CH_W      = 8;
    localparam int END_W     = 6;

    // Endpoint expansion: v * 255 / 31 or / 63, done as a multiply by a
    // scaled reciprocal and a right shift (exact over the 5- and 6-bit ranges).
    localparam logic [7:0]  EXP_SCALE   = 8'd255;
    localparam logic [15:0] RECIP_31    = 16'd33826;
    localparam logic [15:0] RECIP_63    = 16'd16645;
    localparam int          EXP_SHIFT   = 20;
    localparam int          EXP_PROD_W  = 30;

    // Division by 3 of sums up to 765: x * 683 >> 11 (exact below 2048).
    localparam logic [9:0]  RECIP_3     = 10'd683;
    localparam int          DIV3_SHIFT  = 11;
    localparam int          DIV3_PROD_W = 20;

    // Palette index that turns transparent in the three-color mode.
    localparam logic [1:0]  IDX_TRANSP  = 2'd3;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;

    // One channel of the four-entry palette.
    typedef logic [3:0][CH_W-1:0] t_pal_ch;

    // Load strobes of the two front stages.
    typedef struct packed {
        logic load_exp;
        logic load_pal;
    } t_stage_en;

    // Emitter status back to the stage control.
    typedef struct packed {
        logic fire;
        logic block_done;
    } t_emit_stat;

endpackage

>>> rtl/core/dxt1bd_lane.sv
// One color channel lane: endpoint expansion and palette build.
module dxt1bd_lane (
    input  logic                          i_clk,
    input  dxt1bd_pkg::t_stage_en         i_en,
    input  logic                          i_six_bit,
    input  logic [dxt1bd_pkg::END_W-1:0]  i_end0,
    input  logic [dxt1bd_pkg::END_W-1:0]  i_end1,
    input  logic                          i_opaque,
    output dxt1bd_pkg::t_pal_ch           o_pal
);

    logic [13:0]                          w_n0;
    logic [13:0]                          w_n1;
    logic [15:0]                          w_recip;
    logic [dxt1bd_pkg::EXP_PROD_W-1:0]    w_p0;
    logic [dxt1bd_pkg::EXP_PROD_W-1:0]    w_p1;
    logic [dxt1bd_pkg::CH_W-1:0]          r_e0;
    logic [dxt1bd_pkg::CH_W-1:0]          r_e1;
    logic [9:0]                           w_s2;
    logic [9:0]                           w_s3;
    logic [8:0]                           w_sum;
    logic [dxt1bd_pkg::DIV3_PROD_W-1:0]   w_q2;
    logic [dxt1bd_pkg::DIV3_PROD_W-1:0]   w_q3;
    dxt1bd_pkg::t_pal_ch                  n_pal;
    dxt1bd_pkg::t_pal_ch                  r_pal;

    // Expand endpoints to 8 bits.
    assign w_n0    = 14'(i_end0) * 14'(dxt1bd_pkg::EXP_SCALE);
    assign w_n1    = 14'(i_end1) * 14'(dxt1bd_pkg::EXP_SCALE);
    assign w_recip = i_six_bit ? dxt1bd_pkg::RECIP_63 : dxt1bd_pkg::RECIP_31;
    assign w_p0    = dxt1bd_pkg::EXP_PROD_W'(w_n0) * dxt1bd_pkg::EXP_PROD_W'(w_recip);
    assign w_p1    = dxt1bd_pkg::EXP_PROD_W'(w_n1) * dxt1bd_pkg::EXP_PROD_W'(w_recip);

    always_ff @(posedge i_clk) begin
        if (i_en.load_exp) begin
            r_e0 <= w_p0[dxt1bd_pkg::EXP_SHIFT +: dxt1bd_pkg::CH_W];
            r_e1 <= w_p1[dxt1bd_pkg::EXP_SHIFT +: dxt1bd_pkg::CH_W];
        end
    end

    // Interpolated entries.
    assign w_s2  = {1'b0, r_e0, 1'b0} + 10'(r_e1);
    assign w_s3  = 10'(r_e0) + {1'b0, r_e1, 1'b0};
    assign w_sum = 9'(r_e0) + 9'(r_e1);
    assign w_q2  = dxt1bd_pkg::DIV3_PROD_W'(w_s2) * dxt1bd_pkg::DIV3_PROD_W'(dxt1bd_pkg::RECIP_3);
    assign w_q3  = dxt1bd_pkg::DIV3_PROD_W'(w_s3) * dxt1bd_pkg::DIV3_PROD_W'(dxt1bd_pkg::RECIP_3);

    always_comb begin
        n_pal[0] = r_e0;
        n_pal[1] = r_e1;
        if (i_opaque) begin
            n_pal[2] = w_q2[dxt1bd_pkg::DIV3_SHIFT +: dxt1bd_pkg::CH_W];
            n_pal[3] = w_q3[dxt1bd_pkg::DIV3_SHIFT +: dxt1bd_pkg::CH_W];
        end else begin
            n_pal[2] = w_sum[8:1];
            n_pal[3] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_pal) begin
            r_pal <= n_pal;
        end
    end

    assign o_pal = r_pal;

endmodule

>>> rtl/core/dxt1bd_emit.sv
// Texel emitter: merges the lane palettes per index and drives the result port.
module dxt1bd_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_blk_valid,
    input  logic [31:0]                   i_index_bits,
    input  logic                          i_opaque,
    input  dxt1bd_pkg::t_pal_ch           i_pal_red,
    input  dxt1bd_pkg::t_pal_ch           i_pal_green,
    input  dxt1bd_pkg::t_pal_ch           i_pal_blue,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [7:0]                    o_texel_red,
    output logic [7:0]                    o_texel_green,
    output logic [7:0]                    o_texel_blue,
    output logic [7:0]                    o_texel_alpha,
    output logic [1:0]                    o_texel_column,
    output logic [1:0]                    o_texel_row,
    output logic                          o_last_texel,
    output dxt1bd_pkg::t_emit_stat        o_stat
);

    logic [dxt1bd_pkg::CNT_W-1:0] r_cnt;
    logic                         r_valid;
    logic                         w_fire;
    logic [1:0]                   w_sel;
    logic                         w_transp;
    logic [7:0]                   r_red;
    logic [7:0]                   r_green;
    logic [7:0]                   r_blue;
    logic [7:0]                   r_alpha;
    logic [1:0]                   r_col;
    logic [1:0]                   r_row;
    logic                         r_last;

    // Advance when the output register is empty or being drained.
    assign w_fire   = i_blk_valid && (!r_valid || i_out_ready);
    assign w_sel    = i_index_bits[{r_cnt, 1'b0} +: 2];
    assign w_transp = !i_opaque && (w_sel == dxt1bd_pkg::IDX_TRANSP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_cnt   <= r_cnt + 1'b1;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_red   <= i_pal_red[w_sel];
            r_green <= i_pal_green[w_sel];
            r_blue  <= i_pal_blue[w_sel];
            r_alpha <= w_transp ? dxt1bd_pkg::ALPHA_CLEAR : dxt1bd_pkg::ALPHA_OPAQUE;
            r_col   <= r_cnt[1:0];
            r_row   <= r_cnt[3:2];
            r_last  <= &r_cnt;
        end
    end

    assign o_stat.fire       = w_fire;
    assign o_stat.block_done = w_fire && (&r_cnt);

    assign o_out_valid    = r_valid;
    assign o_texel_red    = r_red;
    assign o_texel_green  = r_green;
    assign o_texel_blue   = r_blue;
    assign o_texel_alpha  = r_alpha;
    assign o_texel_column = r_col;
    assign o_texel_row    = r_row;
    assign o_last_texel   = r_last;

endmodule

>>> rtl/core/dxt1_block_decoder_unit.sv
// Top level of the DXT1 (BC1) color block decoder.
//
// Accepts one 8-byte DXT1 block per request (two RGB565 endpoints and 32
// index bits) and returns its 16 RGBA texels in row-major order, texel 0
// first, each tagged with its column and row and with last_texel set on the
// sixteenth. Endpoints expand to 8 bits per channel as v*255/31 (red, blue)
// or v*255/63 (green), truncated. When color_zero > color_one the palette is
// c0, c1, (2c0+c1)/3, (c0+2c1)/3, all opaque; otherwise it is c0, c1,
// (c0+c1)/2 and transparent black. Three channel lanes build the palette in
// two registered stages (expand, then interpolate); the emitter merges the
// lane palettes through the 2-bit index of each texel into an output
// register. Throughput is one texel per clock while the result side does not
// stall, set by the one-texel result channel; blocks stream back to back with
// no gap when the result side never stalls. A request passes the expand
// register and the palette register before the emitter's output register
// holds its first texel. The next request is taken while the current block
// is still being emitted, with one block held in each front stage.
module dxt1_block_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_color_zero,
    input  logic [15:0] i_color_one,
    input  logic [31:0] i_index_bits,
    // Texel channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_texel_red,
    output logic [7:0]  o_texel_green,
    output logic [7:0]  o_texel_blue,
    output logic [7:0]  o_texel_alpha,
    output logic [1:0]  o_texel_column,
    output logic [1:0]  o_texel_row,
    output logic        o_last_texel
);

    // Stage control: stage 1 holds expanded endpoints, stage 2 the palette.
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_mode1;
    logic                       r_mode2;
    logic [31:0]                r_idx1;
    logic [31:0]                r_idx2;
    logic                       w_free1;
    logic                       w_free2;
    dxt1bd_pkg::t_stage_en      w_en;
    dxt1bd_pkg::t_emit_stat     w_stat;
    dxt1bd_pkg::t_pal_ch        w_pal_red;
    dxt1bd_pkg::t_pal_ch        w_pal_green;
    dxt1bd_pkg::t_pal_ch        w_pal_blue;

    // Stage 2 frees up when its block hands over its last texel.
    assign w_free2     = !r_v2 || w_stat.block_done;
    assign w_en.load_pal = r_v1 && w_free2;
    assign w_free1     = !r_v1 || w_en.load_pal;
    assign o_in_ready  = w_free1;
    assign w_en.load_exp = i_in_valid && w_free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en.load_exp) begin
                r_v1 <= 1'b1;
            end else if (w_en.load_pal) begin
                r_v1 <= 1'b0;
            end
            if (w_en.load_pal) begin
                r_v2 <= 1'b1;
            end else if (w_stat.block_done) begin
                r_v2 <= 1'b0;
            end
        end
    end

    // Carry the mode and the index bits alongside the lane data.
    always_ff @(posedge i_clk) begin
        if (w_en.load_exp) begin
            r_mode1 <= i_color_zero > i_color_one;
            r_idx1  <= i_index_bits;
        end
        if (w_en.load_pal) begin
            r_mode2 <= r_mode1;
            r_idx2  <= r_idx1;
        end
    end

    dxt1bd_lane u_lane_red (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_six_bit (1'b0),
        .i_end0    ({1'b0, i_color_zero[15:11]}),
        .i_end1    ({1'b0, i_color_one[15:11]}),
        .i_opaque  (r_mode1),
        .o_pal     (w_pal_red)
    );

    dxt1bd_lane u_lane_green (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_six_bit (1'b1),
        .i_end0    (i_color_zero[10:5]),
        .i_end1    (i_color_one[10:5]),
        .i_opaque  (r_mode1),
        .o_pal     (w_pal_green)
    );

    dxt1bd_lane u_lane_blue (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_six_bit (1'b0),
        .i_end0    ({1'b0, i_color_zero[4:0]}),
        .i_end1    ({1'b0, i_color_one[4:0]}),
        .i_opaque  (r_mode1),
        .o_pal     (w_pal_blue)
    );

    // Merge the lane palettes per texel and drive the texel channel.
    dxt1bd_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_blk_valid    (r_v2),
        .i_index_bits   (r_idx2),
        .i_opaque       (r_mode2),
        .i_pal_red      (w_pal_red),
        .i_pal_green    (w_pal_green),
        .i_pal_blue     (w_pal_blue),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_texel_red    (o_texel_red),
        .o_texel_green  (o_texel_green),
        .o_texel_blue   (o_texel_blue),
        .o_texel_alpha  (o_texel_alpha),
        .o_texel_column (o_texel_column),
        .o_texel_row    (o_texel_row),
        .o_last_texel   (o_last_texel),
        .o_stat         (w_stat)
    );

endmodule

>>> tb/sv/tb_dxt1_block_decoder_unit.sv
// Self-checking testbench for the DXT1 block decoder: directed and random blocks, texel checks.
`timescale 1ns / 100ps

module tb_dxt1_block_decoder_unit;

    // Wait after the last texel before a phase change or the end of the run;
    // this leaves plenty of slack for the pipeline to settle.
    localparam int SETTLE_CYCLES = 24;
    // Bounds the slowest correct run: 114 blocks of 16 texels under long stalls.
    localparam int CYCLE_LIMIT   = 400_000;

    // Channel slots of the working palette.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // One decoded texel as it should appear on the texel channel.
    typedef struct packed {
        logic [dxt1bd_pkg::CH_W-1:0] red;
        logic [dxt1bd_pkg::CH_W-1:0] green;
        logic [dxt1bd_pkg::CH_W-1:0] blue;
        logic [dxt1bd_pkg::CH_W-1:0] alpha;
        logic [1:0]                  column;
        logic [1:0]                  row;
        logic                        last;
    } t_texel;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [15:0] color_zero = '0;
    logic [15:0] color_one = '0;
    logic [31:0] index_bits = '0;

    logic        texel_valid;
    logic        texel_ready = 1'b0;
    logic [7:0]  texel_red;
    logic [7:0]  texel_green;
    logic [7:0]  texel_blue;
    logic [7:0]  texel_alpha;
    logic [1:0]  texel_column;
    logic [1:0]  texel_row;
    logic        last_texel;

    // Texels predicted for accepted requests, oldest first.
    t_texel pending_texels[$];

    int mismatch_count = 0;
    int cycle_count = 0;

    // Request-side pacing: idle cycles before the next request, and whether
    // valid is still high from the previous request (back-to-back case).
    bit source_gaps_on = 1'b1;
    int gap_ahead = 0;
    bit req_held = 1'b0;

    // Texel-side pacing: chance in percent to start a stall after a ready cycle.
    int sink_stall_pct = 20;
    int stall_left = 0;

    dxt1_block_decoder_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_ready     (req_ready),
        .i_color_zero   (color_zero),
        .i_color_one    (color_one),
        .i_index_bits   (index_bits),
        .o_out_valid    (texel_valid),
        .i_out_ready    (texel_ready),
        .o_texel_red    (texel_red),
        .o_texel_green  (texel_green),
        .o_texel_blue   (texel_blue),
        .o_texel_alpha  (texel_alpha),
        .o_texel_column (texel_column),
        .o_texel_row    (texel_row),
        .o_last_texel   (last_texel)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Build the four-entry palette of one block and queue its 16 texels in
    // row-major order, indices taken from the low bits upward.
    function automatic void decode_block(input logic [15:0] c0, input logic [15:0] c1,
                                         input logic [31:0] idx);
        int     ep_zero [3];
        int     ep_one [3];
        int     pal [4][3];
        bit     four_color;
        t_texel t;
        logic [1:0] sel;
        int     ch;
        int     k;

        // Expand RGB565 to 8 bits per channel, truncating.
        ep_zero[CH_RED]   = int'(c0[15:11]) * 255 / 31;
        ep_zero[CH_GREEN] = int'(c0[10:5]) * 255 / 63;
        ep_zero[CH_BLUE]  = int'(c0[4:0]) * 255 / 31;
        ep_one[CH_RED]    = int'(c1[15:11]) * 255 / 31;
        ep_one[CH_GREEN]  = int'(c1[10:5]) * 255 / 63;
        ep_one[CH_BLUE]   = int'(c1[4:0]) * 255 / 31;

        // Equal endpoints fall into the three-color mode.
        four_color = (c0 > c1);

        for (ch = 0; ch < 3; ch++) begin
            pal[0][ch] = ep_zero[ch];
            pal[1][ch] = ep_one[ch];
            if (four_color) begin
                pal[2][ch] = (2 * ep_zero[ch] + ep_one[ch]) / 3;
                pal[3][ch] = (ep_zero[ch] + 2 * ep_one[ch]) / 3;
            end else begin
                pal[2][ch] = (ep_zero[ch] + ep_one[ch]) / 2;
                pal[3][ch] = 0;
            end
        end

        for (k = 0; k < dxt1bd_pkg::TEXELS; k++) begin
            sel      = idx[2*k +: 2];
            t.red    = dxt1bd_pkg::CH_W'(pal[sel][CH_RED]);
            t.green  = dxt1bd_pkg::CH_W'(pal[sel][CH_GREEN]);
            t.blue   = dxt1bd_pkg::CH_W'(pal[sel][CH_BLUE]);
            // Only the last entry of the three-color palette is see-through.
            t.alpha  = (!four_color && sel == dxt1bd_pkg::IDX_TRANSP) ?
                       dxt1bd_pkg::ALPHA_CLEAR : dxt1bd_pkg::ALPHA_OPAQUE;
            t.column = 2'(k % 4);
            t.row    = 2'(k / 4);
            t.last   = (k == dxt1bd_pkg::TEXELS - 1);
            pending_texels = {pending_texels, t};
        end
    endfunction

    // Compare one field; count and report a mismatch. Unknown bits never match.
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Pop the oldest predicted texel and compare the texel on the port with it.
    function automatic void check_texel();
        t_texel want;
        if (pending_texels.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: texel with none expected, expected none, got rgba %0h %0h %0h %0h",
                     $time, texel_red, texel_green, texel_blue, texel_alpha);
            return;
        end
        want = pending_texels.pop_front();
        check_field("red",    32'(want.red),    32'(texel_red));
        check_field("green",  32'(want.green),  32'(texel_green));
        check_field("blue",   32'(want.blue),   32'(texel_blue));
        check_field("alpha",  32'(want.alpha),  32'(texel_alpha));
        check_field("column", 32'(want.column), 32'(texel_column));
        check_field("row",    32'(want.row),    32'(texel_row));
        check_field("last",   32'(want.last),   32'(last_texel));
    endfunction

    // Texel side: check on the handshake as seen at this edge, then decide
    // ready for the next cycle. A stall of zero percent keeps ready high.
    always @(posedge clk) begin
        if (rst_n && texel_valid === 1'b1 && texel_ready) begin
            check_texel();
        end
        if (stall_left > 0) begin
            texel_ready <= 1'b0;
            stall_left--;
        end else begin
            texel_ready <= 1'b1;
            if ($urandom_range(0, 99) < sink_stall_pct) begin
                stall_left = 1 + pick_gap();
            end
        end
    end

    // Guard against a hang: the run ends here if it takes far too long.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one block request. Idle first if a gap was drawn, hold valid and
    // payload until the request is taken, then queue the predicted texels.
    // Drop valid right away when the next request is not back to back, so
    // valid never falls and rises in the same step.
    task automatic send_block(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [31:0] idx);
        repeat (gap_ahead) @(posedge clk);
        req_valid  <= 1'b1;
        color_zero <= c0;
        color_one  <= c1;
        index_bits <= idx;
        req_held = 1'b0;
        do @(posedge clk); while (req_ready !== 1'b1);
        decode_block(c0, c1, idx);
        gap_ahead = source_gaps_on ? pick_gap() : 0;
        if (gap_ahead != 0) begin
            req_valid <= 1'b0;
        end else begin
            req_held = 1'b1;
        end
    endtask

    // Stop requesting and wait for every predicted texel, then let the
    // pipeline settle.
    task automatic wait_for_texels();
        if (req_held) begin
            req_valid <= 1'b0;
            req_held = 1'b0;
        end
        while (pending_texels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Endpoint extremes, both palette modes, equal endpoints, transparent
    // index and every index in every texel position.
    task automatic test_directed_endpoints();
        source_gaps_on = 1'b1;
        sink_stall_pct = 20;
        send_block(16'h0000, 16'h0000, 32'h0000_0000);
        send_block(16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
        send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
        send_block(16'hFFFF, 16'hFFFF, 32'hE4E4_E4E4);
        send_block(16'hF800, 16'h07E0, 32'h1B1B_1B1B);
        send_block(16'h001F, 16'hF800, 32'hAAAA_AAAA);
        send_block(16'hFFFF, 16'hFFFE, 32'h5555_5555);
        send_block(16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF);
        send_block(16'h07E0, 16'h001F, 32'hAAAA_AAAA);
        send_block(16'h8410, 16'h7BEF, 32'hE4E4_E4E4);
        send_block(16'h5555, 16'hAAAA, 32'h5555_AAAA);
        send_block(16'hAAAA, 16'h5555, 32'hAAAA_5555);
        send_block(16'h0001, 16'h0000, 32'hE4E4_1B1B);
        // Hold off until the decoder has drained completely.
        wait_for_texels();
    endtask

    // Random blocks with color_zero above color_one: interpolated palette.
    task automatic test_four_color_blocks();
        logic [15:0] a;
        logic [15:0] b;
        int          n;
        source_gaps_on = 1'b1;
        sink_stall_pct = 20;
        for (n = 0; n < 25; n++) begin
            a = 16'($urandom());
            b = 16'($urandom());
            if (a == b) b = a ^ 16'h0001;
            if (a < b) send_block(b, a, $urandom());
            else send_block(a, b, $urandom());
        end
    endtask

    // Random blocks with color_zero not above color_one: midpoint palette
    // and transparent black, equal endpoints now and then.
    task automatic test_three_color_blocks();
        logic [15:0] a;
        logic [15:0] b;
        int          n;
        source_gaps_on = 1'b1;
        sink_stall_pct = 20;
        for (n = 0; n < 25; n++) begin
            a = 16'($urandom());
            b = 16'($urandom());
            if ($urandom_range(0, 4) == 0) b = a;
            if (a > b) send_block(b, a, $urandom());
            else send_block(a, b, $urandom());
        end
    endtask

    // Back-to-back requests with the texel side always ready: full rate.
    task automatic test_streaming();
        int n;
        source_gaps_on = 1'b0;
        sink_stall_pct = 0;
        for (n = 0; n < 20; n++) begin
            send_block(16'($urandom()), 16'($urandom()), $urandom());
        end
    endtask

    // Frequent texel-side stalls so the front stages fill and back up.
    task automatic test_stall_storm();
        int n;
        source_gaps_on = 1'b1;
        sink_stall_pct = 70;
        for (n = 0; n < 15; n++) begin
            send_block(16'($urandom()), 16'($urandom()), $urandom());
        end
        wait_for_texels();
    endtask

    // Fully random blocks with idling on both sides.
    task automatic test_mixed_random();
        logic [15:0] a;
        int          n;
        source_gaps_on = 1'b1;
        sink_stall_pct = 25;
        for (n = 0; n < 15; n++) begin
            a = 16'($urandom());
            if ($urandom_range(0, 5) == 0) send_block(a, a, $urandom());
            else send_block(a, 16'($urandom()), $urandom());
        end
    endtask

    initial begin
        // Hold reset at the start, release it once and never again.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_endpoints();
        test_four_color_blocks();
        test_three_color_blocks();
        test_streaming();
        test_stall_storm();
        test_mixed_random();

        wait_for_texels();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
